/* rtl/core/tccs_pkg.sv */
// Shared types and constants for the text console cursor and scroll unit.
package tccs_pkg;

    localparam int CHAR_W  = 8;
    localparam int COLOR_W = 8;
    localparam int INDEX_W = 11;
    localparam int WORD_W  = 16;
    localparam int OROW_W  = 5;
    localparam int OCOL_W  = 7;

    localparam logic [CHAR_W-1:0] CH_NEWLINE = 8'd10;
    localparam logic [CHAR_W-1:0] CH_RETURN  = 8'd13;
    localparam logic [CHAR_W-1:0] CH_BLANK   = 8'd32;

    localparam logic [COLOR_W-1:0] DEFAULT_COLOR_RST = 8'd23;

    typedef enum logic [1:0] {
        REQ_PUT   = 2'd0,
        REQ_CLEAR = 2'd1,
        REQ_HOME  = 2'd2,
        REQ_READ  = 2'd3
    } req_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_READ,
        ST_SCROLL,
        ST_FILL
    } state_t;

endpackage

/* rtl/core/text_console_cursor_scroll_unit.sv */
// Text console engine: cell store, cursor, scroll and clear sequencer.
//
// Channel   | Dir | Handshake                    | Payload
// ----------+-----+------------------------------+-------------------------------------------
// s_axis    | in  | s_axis_tvalid/s_axis_tready  | tuser: req_type; tdata: char, color, index
// m_axis    | out | m_axis_tvalid/m_axis_tready  | tdata: cell_word, row, col, did_scroll
// cfg       | in  | cfg_wr_en                    | cfg_wr_data: default_color
//
// Put of an ordinary character, newline or carriage return completes straight from idle, unless it scrolls.
// Read: passes through ST_READ (registered read port of the cell store).
// Clear or home: blank every cell in ST_FILL, one store write per cycle.
// Scroll: in ST_SCROLL copy each cell up one row, then blank the last row in ST_FILL.
// Reset clears cursor, sequencer and output valid; the store stays undefined until cleared.
// A new item is taken only in idle and only while the output register is free or draining.
module text_console_cursor_scroll_unit #(
    parameter int COLUMNS = 80,
    parameter int ROWS    = 25
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [31:0] s_axis_tdata,  // [7:0] char_code, [15:8] char_color, [26:16] cell_index
    input  logic [1:0]  s_axis_tuser,  // [1:0] req_type
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [31:0] m_axis_tdata,  // [15:0] cell_word, [20:16] cursor_row,
                                       // [27:21] cursor_col, [28] did_scroll
    input  logic        cfg_wr_en,
    input  logic [7:0]  cfg_wr_data
);

    localparam int CELLS     = ROWS * COLUMNS;
    localparam int AW        = $clog2(CELLS);
    localparam int RW        = $clog2(ROWS);
    localparam int CW        = $clog2(COLUMNS);
    localparam int COPY_N    = CELLS - COLUMNS;

    tccs_pkg::state_t state_reg, state_next;

    logic [RW-1:0] row_reg, row_next;
    logic [CW-1:0] col_reg, col_next;
    logic [AW-1:0] base_reg, base_next;
    logic [AW-1:0] cnt_reg, cnt_next;
    logic          scroll_reg, scroll_next;
    logic [7:0]    default_color_reg;

    logic          m_valid_reg, m_valid_next;
    logic [15:0]   m_word_reg;
    logic [4:0]    m_row_reg;
    logic [6:0]    m_col_reg;
    logic          m_scroll_reg;

    logic [15:0]   cells_mem [CELLS];
    logic [15:0]   rd_data_reg;
    logic [AW-1:0] rd_addr;
    logic          wr_en;
    logic [AW-1:0] wr_addr;
    logic [15:0]   wr_data;

    logic          done;
    logic [15:0]   done_word;
    logic          done_scroll;
    logic          accept;

    tccs_pkg::req_t req;
    logic [7:0]     in_char;
    logic [7:0]     in_color;
    logic [10:0]    in_index;
    logic           in_range;
    logic [15:0]    blank_word;

    assign req        = tccs_pkg::req_t'(s_axis_tuser);
    assign in_char    = s_axis_tdata[7:0];
    assign in_color   = s_axis_tdata[15:8];
    assign in_index   = s_axis_tdata[26:16];
    assign in_range   = (32'(in_index) < 32'(CELLS));
    assign blank_word = {default_color_reg, tccs_pkg::CH_BLANK};

    assign s_axis_tready = (state_reg == tccs_pkg::ST_IDLE) && (!m_valid_reg || m_axis_tready);
    assign accept        = s_axis_tvalid && s_axis_tready;

    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tdata  = {3'b000, m_scroll_reg, m_col_reg, m_row_reg, m_word_reg};

    always_comb
    begin
        state_next  = state_reg;
        row_next    = row_reg;
        col_next    = col_reg;
        base_next   = base_reg;
        cnt_next    = cnt_reg;
        scroll_next = scroll_reg;
        done        = 1'b0;
        done_word   = '0;
        done_scroll = 1'b0;
        wr_en       = 1'b0;
        wr_addr     = base_reg + AW'(col_reg);
        wr_data     = {in_color, in_char};
        rd_addr     = AW'(in_index);

        unique case (state_reg)
            tccs_pkg::ST_IDLE:
            begin
                if (accept)
                begin
                    unique case (req)
                        tccs_pkg::REQ_PUT:
                        begin
                            if (in_char != tccs_pkg::CH_RETURN && in_char != tccs_pkg::CH_NEWLINE)
                            begin
                                wr_en = 1'b1;
                            end
                            if (in_char == tccs_pkg::CH_RETURN)
                            begin
                                col_next = '0;
                                done     = 1'b1;
                            end
                            else if (in_char != tccs_pkg::CH_NEWLINE &&
                                     col_reg != CW'(COLUMNS - 1))
                            begin
                                col_next = col_reg + 1'b1;
                                done     = 1'b1;
                            end
                            else
                            begin
                                // next row, or scroll from the last one
                                col_next = '0;
                                if (row_reg == RW'(ROWS - 1))
                                begin
                                    cnt_next    = '0;
                                    scroll_next = 1'b1;
                                    state_next  = tccs_pkg::ST_SCROLL;
                                end
                                else
                                begin
                                    row_next  = row_reg + 1'b1;
                                    base_next = base_reg + AW'(COLUMNS);
                                    done      = 1'b1;
                                end
                            end
                        end
                        tccs_pkg::REQ_CLEAR:
                        begin
                            cnt_next    = '0;
                            scroll_next = 1'b0;
                            state_next  = tccs_pkg::ST_FILL;
                        end
                        tccs_pkg::REQ_HOME:
                        begin
                            row_next    = '0;
                            col_next    = '0;
                            base_next   = '0;
                            cnt_next    = '0;
                            scroll_next = 1'b0;
                            state_next  = tccs_pkg::ST_FILL;
                        end
                        tccs_pkg::REQ_READ:
                        begin
                            if (in_range)
                            begin
                                state_next = tccs_pkg::ST_READ;
                            end
                            else
                            begin
                                done = 1'b1;
                            end
                        end
                        default:
                        begin
                            done = 1'b1;
                        end
                    endcase
                end
            end
            tccs_pkg::ST_READ:
            begin
                done       = 1'b1;
                done_word  = rd_data_reg;
                state_next = tccs_pkg::ST_IDLE;
            end
            tccs_pkg::ST_SCROLL:
            begin
                // read one row ahead, write the cell read last cycle
                rd_addr = AW'(32'(cnt_reg) + COLUMNS);
                wr_en   = (cnt_reg != '0);
                wr_addr = cnt_reg - 1'b1;
                wr_data = rd_data_reg;
                if (cnt_reg == AW'(COPY_N))
                begin
                    state_next = tccs_pkg::ST_FILL;
                end
                else
                begin
                    cnt_next = cnt_reg + 1'b1;
                end
            end
            tccs_pkg::ST_FILL:
            begin
                wr_en   = 1'b1;
                wr_addr = cnt_reg;
                wr_data = blank_word;
                if (cnt_reg == AW'(CELLS - 1))
                begin
                    done        = 1'b1;
                    done_scroll = scroll_reg;
                    state_next  = tccs_pkg::ST_IDLE;
                end
                else
                begin
                    cnt_next = cnt_reg + 1'b1;
                end
            end
            default:
            begin
                state_next = tccs_pkg::ST_IDLE;
            end
        endcase

        m_valid_next = done || (m_valid_reg && !m_axis_tready);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= tccs_pkg::ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_reg           <= '0;
            col_reg           <= '0;
            base_reg          <= '0;
            cnt_reg           <= '0;
            scroll_reg        <= 1'b0;
            m_valid_reg       <= 1'b0;
            default_color_reg <= tccs_pkg::DEFAULT_COLOR_RST;
        end
        else
        begin
            row_reg     <= row_next;
            col_reg     <= col_next;
            base_reg    <= base_next;
            cnt_reg     <= cnt_next;
            scroll_reg  <= scroll_next;
            m_valid_reg <= m_valid_next;
            if (cfg_wr_en)
            begin
                default_color_reg <= cfg_wr_data;
            end
        end
    end

    // result payload, loaded when an item finishes
    always_ff @(posedge clk)
    begin
        if (done)
        begin
            m_word_reg   <= done_word;
            m_row_reg    <= 5'(row_next);
            m_col_reg    <= 7'(col_next);
            m_scroll_reg <= done_scroll;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            cells_mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        rd_data_reg <= cells_mem[rd_addr];
    end

endmodule

/* rtl/core/tccs_checker.sv */
// Port-level checks for the text console unit, bound into text_console_cursor_scroll_unit.
module tccs_checker #(
    parameter int COLUMNS = 80,
    parameter int ROWS    = 25
) (
    input logic        clk,
    input logic        rst_n,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [31:0] m_axis_tdata
);

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("result item dropped or changed while stalled");

    a_row_range: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> (ROWS > 32) || (32'(m_axis_tdata[20:16]) < ROWS))
        else $error("cursor row beyond last row");

    a_col_range: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> (COLUMNS > 128) || (32'(m_axis_tdata[27:21]) < COLUMNS))
        else $error("cursor column beyond last column");

    a_scroll_home: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tdata[28] |->
            m_axis_tdata[27:21] == 7'd0 && m_axis_tdata[15:0] == 16'd0 &&
            ((ROWS > 32) || (32'(m_axis_tdata[20:16]) == ROWS - 1)))
        else $error("scroll result without cursor on last row, column zero");

endmodule

bind text_console_cursor_scroll_unit tccs_checker #(
    .COLUMNS (COLUMNS),
    .ROWS    (ROWS)
) u_tccs_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);
